>>> rtl/mgc_pkg.sv
// Package for the motorized gate controller: word types, codes and register map.
package mgc_pkg;

	// Default width of the saturating millisecond counters
	localparam int unsigned TICK_COUNTER_BITS_DEF = 24;

	// Width of the tick-count configuration registers
	localparam int unsigned CFG_TICK_W = 24;

	// Configuration register reset values
	localparam logic                  HAS_LS_RST     = 1'b1;
	localparam logic [CFG_TICK_W-1:0] RUN_TICKS_RST  = 24'd30000;
	localparam logic [CFG_TICK_W-1:0] SETTLE_TICKS_RST = 24'd2000;

	// APB address width and register indexes (byte address 4*index)
	localparam int unsigned PADDR_W = 4;
	localparam logic [1:0] REG_HAS_LS       = 2'd0;
	localparam logic [1:0] REG_RUN_TICKS    = 2'd1;
	localparam logic [1:0] REG_SETTLE_TICKS = 2'd2;

	// Event codes
	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_OPEN  = 3'd1,
		OP_CLOSE = 3'd2,
		OP_BOOT  = 3'd3,
		OP_TAKE  = 3'd4
	} op_t;

	// Gate position codes
	typedef enum logic [2:0] {
		POS_UNKNOWN = 3'd0,
		POS_CLOSED  = 3'd1,
		POS_OPEN    = 3'd2,
		POS_OPENING = 3'd3,
		POS_CLOSING = 3'd4
	} pos_t;

	// Stored position codes
	localparam logic [1:0] SP_CLOSED = 2'd1;
	localparam logic [1:0] SP_OPEN   = 2'd2;

	// Request outcome codes
	typedef enum logic [2:0] {
		RES_OK       = 3'd0,
		RES_ESTOP    = 3'd1,
		RES_MOVING   = 3'd2,
		RES_SETTLING = 3'd3,
		RES_ALREADY  = 3'd4
	} res_t;

	// Motor drive direction
	typedef enum logic [1:0] {
		DIR_OFF   = 2'd0,
		DIR_OPEN  = 2'd1,
		DIR_CLOSE = 2'd2
	} dir_t;

	// Input word
	typedef struct packed {
		logic [2:0] op;
		logic       limit_open;
		logic       limit_closed;
		logic       estop_engaged;
		logic [1:0] stored_position;
	} req_word_t;

	// Result word
	typedef struct packed {
		logic [2:0] gate_state;
		logic [2:0] request_result;
		logic       drive_open;
		logic       drive_close;
		logic       persist_write;
		logic [1:0] persist_code;
		logic       changed_flag;
	} rsp_word_t;

	// Configuration handed to the engine
	typedef struct packed {
		logic                  has_limit_switches;
		logic [CFG_TICK_W-1:0] motor_run_ticks;
		logic [CFG_TICK_W-1:0] settle_ticks;
	} cfg_t;

endpackage

>>> rtl/motorized_gate_controller.sv
// Top level of the motorized gate controller: handshake registers and APB registers.
//
// Takes one event word per clock cycle and returns exactly one result word for each.
// An event word is held in the input register after its accepting edge, and its result
// word is loaded into the result register when that register is empty or being taken, at
// which point rsp_valid rises. The input register moves on whenever the result register
// is empty or being taken, so the block accepts a new word in every cycle unless the
// result side stalls. Events are ticks, open/close requests, boot and a changed-flag
// query; registers has_limit_switches (0x0), motor_run_ticks (0x4) and settle_ticks
// (0x8) are written over APB; the user must write them only while idle, which the
// block does not enforce.
module motorized_gate_controller #(
	parameter int unsigned TICK_COUNTER_BITS = mgc_pkg::TICK_COUNTER_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  mgc_pkg::req_word_t          req_word,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output mgc_pkg::rsp_word_t          rsp_word,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mgc_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	mgc_pkg::req_word_t req_s1;
	logic               req_vld_s1;
	mgc_pkg::rsp_word_t rsp_s2, rsp_n;
	logic               rsp_vld_s2;
	logic               advance;
	mgc_pkg::cfg_t      cfg_q;

	// Move the input register on when the result register frees up
	assign advance   = !rsp_vld_s2 || rsp_ready;
	assign req_ready = !req_vld_s1 || advance;
	assign rsp_valid = rsp_vld_s2;
	assign rsp_word  = rsp_s2;
	assign pready    = 1'b1;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_s1 <= 1'b0;
			rsp_vld_s2 <= 1'b0;
		end else begin
			if (req_ready) req_vld_s1 <= req_valid;
			if (advance) rsp_vld_s2 <= req_vld_s1;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (req_ready && req_valid) req_s1 <= req_word;
		if (advance && req_vld_s1) rsp_s2 <= rsp_n;
	end

	mgc_engine #(
		.TICK_COUNTER_BITS(TICK_COUNTER_BITS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (req_vld_s1 && advance),
		.item   (req_s1),
		.cfg    (cfg_q),
		.result (rsp_n)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.has_limit_switches <= mgc_pkg::HAS_LS_RST;
			cfg_q.motor_run_ticks    <= mgc_pkg::RUN_TICKS_RST;
			cfg_q.settle_ticks       <= mgc_pkg::SETTLE_TICKS_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				mgc_pkg::REG_HAS_LS:       cfg_q.has_limit_switches <= pwdata[0];
				mgc_pkg::REG_RUN_TICKS:    cfg_q.motor_run_ticks <= pwdata[mgc_pkg::CFG_TICK_W-1:0];
				mgc_pkg::REG_SETTLE_TICKS: cfg_q.settle_ticks <= pwdata[mgc_pkg::CFG_TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back
	always_comb begin
		case (paddr[3:2])
			mgc_pkg::REG_HAS_LS:       prdata = {31'd0, cfg_q.has_limit_switches};
			mgc_pkg::REG_RUN_TICKS:    prdata = 32'(cfg_q.motor_run_ticks);
			mgc_pkg::REG_SETTLE_TICKS: prdata = 32'(cfg_q.settle_ticks);
			default:                   prdata = 32'd0;
		endcase
	end

endmodule

>>> rtl/mgc_engine.sv
// Gate controller state registers and the per-word next-state logic.
module mgc_engine #(
	parameter int unsigned TICK_COUNTER_BITS = mgc_pkg::TICK_COUNTER_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  mgc_pkg::req_word_t item,
	input  mgc_pkg::cfg_t      cfg,
	output mgc_pkg::rsp_word_t result
);

	localparam int unsigned CW = (TICK_COUNTER_BITS > mgc_pkg::CFG_TICK_W) ?
		TICK_COUNTER_BITS : mgc_pkg::CFG_TICK_W;
	localparam logic [TICK_COUNTER_BITS-1:0] CNT_MAX = {TICK_COUNTER_BITS{1'b1}};

	mgc_pkg::pos_t pos_q, pos_n, halt_pos, seen, target;
	mgc_pkg::dir_t dir_q, dir_n;
	mgc_pkg::res_t rr;
	logic est_q, est_n, chg_q, chg_n, ever_q, ever_n;
	logic [TICK_COUNTER_BITS-1:0] run_q, run_n, ss_q, ss_n;
	logic pw, cf, halt, moving, timed_out, want_open;
	logic [1:0] pcode;

	// Position seen on the limit switches: exactly one must be reached
	function automatic mgc_pkg::pos_t seen_pos(input logic lo, input logic lc);
		mgc_pkg::pos_t p;
		p = mgc_pkg::POS_UNKNOWN;
		if (lo && !lc) p = mgc_pkg::POS_OPEN;
		else if (lc && !lo) p = mgc_pkg::POS_CLOSED;
		return p;
	endfunction

	// Next state and result word
	always_comb begin
		pos_n     = pos_q;
		dir_n     = dir_q;
		est_n     = est_q;
		chg_n     = chg_q;
		ever_n    = ever_q;
		run_n     = run_q;
		ss_n      = ss_q;
		rr        = mgc_pkg::RES_OK;
		pw        = 1'b0;
		pcode     = 2'd0;
		cf        = 1'b0;
		halt      = 1'b0;
		halt_pos  = mgc_pkg::POS_UNKNOWN;
		timed_out = 1'b0;
		seen      = seen_pos(item.limit_open, item.limit_closed);
		moving    = (pos_q == mgc_pkg::POS_OPENING) || (pos_q == mgc_pkg::POS_CLOSING);
		want_open = (item.op == mgc_pkg::OP_OPEN);
		target    = want_open ? mgc_pkg::POS_OPEN : mgc_pkg::POS_CLOSED;

		case (item.op)
			mgc_pkg::OP_TICK: begin
				// advance both counters, saturating
				run_n = (run_q == CNT_MAX) ? run_q : run_q + TICK_COUNTER_BITS'(1);
				ss_n  = (ss_q == CNT_MAX) ? ss_q : ss_q + TICK_COUNTER_BITS'(1);
				if (item.estop_engaged != est_q) begin
					est_n = item.estop_engaged;
					chg_n = 1'b1;
				end
				timed_out = (CW'(run_n) >= CW'(cfg.motor_run_ticks)) || (run_n == CNT_MAX);
				if (est_n && (moving || dir_q != mgc_pkg::DIR_OFF)) begin
					halt = 1'b1;
				end else if (!moving) begin
					// idle: follow the limit switches
					dir_n = mgc_pkg::DIR_OFF;
					if (cfg.has_limit_switches && seen != pos_q) begin
						pos_n = seen;
						chg_n = 1'b1;
						pw    = 1'b1;
						pcode = seen[1:0];
					end
				end else if (cfg.has_limit_switches) begin
					if (pos_q == mgc_pkg::POS_OPENING && item.limit_open) begin
						halt     = 1'b1;
						halt_pos = mgc_pkg::POS_OPEN;
					end else if (pos_q == mgc_pkg::POS_CLOSING && item.limit_closed) begin
						halt     = 1'b1;
						halt_pos = mgc_pkg::POS_CLOSED;
					end else if (timed_out) begin
						halt = 1'b1;
					end
				end else if (timed_out) begin
					// no switches: run timeout means arrival
					halt     = 1'b1;
					halt_pos = (pos_q == mgc_pkg::POS_OPENING) ?
						mgc_pkg::POS_OPEN : mgc_pkg::POS_CLOSED;
				end
			end
			mgc_pkg::OP_OPEN, mgc_pkg::OP_CLOSE: begin
				if (est_q) begin
					rr = mgc_pkg::RES_ESTOP;
				end else if (moving) begin
					rr = mgc_pkg::RES_MOVING;
				end else if (ever_q && (CW'(ss_q) < CW'(cfg.settle_ticks)) &&
						(ss_q != CNT_MAX)) begin
					rr = mgc_pkg::RES_SETTLING;
				end else if (pos_q == target) begin
					rr = mgc_pkg::RES_ALREADY;
				end else begin
					// start the motor
					pw    = 1'b1;
					pcode = 2'd0;
					pos_n = want_open ? mgc_pkg::POS_OPENING : mgc_pkg::POS_CLOSING;
					chg_n = 1'b1;
					run_n = '0;
					dir_n = want_open ? mgc_pkg::DIR_OPEN : mgc_pkg::DIR_CLOSE;
				end
			end
			mgc_pkg::OP_BOOT: begin
				dir_n = mgc_pkg::DIR_OFF;
				est_n = item.estop_engaged;
				chg_n = 1'b1;
				if (cfg.has_limit_switches) pos_n = seen;
				else if (item.stored_position == mgc_pkg::SP_CLOSED) pos_n = mgc_pkg::POS_CLOSED;
				else if (item.stored_position == mgc_pkg::SP_OPEN) pos_n = mgc_pkg::POS_OPEN;
				else pos_n = mgc_pkg::POS_UNKNOWN;
			end
			mgc_pkg::OP_TAKE: begin
				cf    = chg_q;
				chg_n = 1'b0;
			end
			default: begin
			end
		endcase

		// stop the motor and record where it stopped
		if (halt) begin
			dir_n  = mgc_pkg::DIR_OFF;
			ss_n   = '0;
			ever_n = 1'b1;
			pw     = 1'b1;
			pcode  = halt_pos[1:0];
			if (halt_pos != pos_q) begin
				pos_n = halt_pos;
				chg_n = 1'b1;
			end
		end

		result.gate_state     = pos_n;
		result.request_result = rr;
		result.drive_open     = (dir_n == mgc_pkg::DIR_OPEN);
		result.drive_close    = (dir_n == mgc_pkg::DIR_CLOSE);
		result.persist_write  = pw;
		result.persist_code   = pcode;
		result.changed_flag   = cf;
	end

	// Commit the state on each processed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= mgc_pkg::POS_UNKNOWN;
			dir_q  <= mgc_pkg::DIR_OFF;
			est_q  <= 1'b0;
			chg_q  <= 1'b0;
			ever_q <= 1'b0;
			run_q  <= '0;
			ss_q   <= '0;
		end else if (step) begin
			pos_q  <= pos_n;
			dir_q  <= dir_n;
			est_q  <= est_n;
			chg_q  <= chg_n;
			ever_q <= ever_n;
			run_q  <= run_n;
			ss_q   <= ss_n;
		end
	end

endmodule

>>> rtl/mgc_checker.sv
// Port-level checker for the motorized gate controller, bound to the top level.
module mgc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input mgc_pkg::rsp_word_t rsp_word
);

	// Hold a stalled result word
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
		else $error("result word changed while stalled");

	// Never drive the motor both ways
	a_one_dir: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_word.drive_open && rsp_word.drive_close))
		else $error("both drive directions on");

	// Drive direction follows the moving state
	a_drive_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_word.drive_open == (rsp_word.gate_state == mgc_pkg::POS_OPENING)) &&
			(rsp_word.drive_close == (rsp_word.gate_state == mgc_pkg::POS_CLOSING)))
		else $error("drive outputs disagree with gate state");

	// A refused request writes nothing and reports no flag
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.request_result != mgc_pkg::RES_OK |->
			!rsp_word.persist_write && !rsp_word.changed_flag)
		else $error("refused request caused a side effect");

	// Drop the persist code when nothing is written
	a_code_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_word.persist_write |-> rsp_word.persist_code == 2'd0)
		else $error("persist code set without a write");

endmodule

bind motorized_gate_controller mgc_checker u_mgc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp_word  (rsp_word)
);
